### rtl/mffu_pkg.sv
`default_nettype none

package mffu_pkg;

    localparam int WordBits   = 32;
    localparam int FieldMax   = 16;
    localparam int MaxResults = 32;
    localparam int AccBits    = 2 * WordBits;
    localparam int CntBits    = 8;
    localparam int WidthBits  = 5;
    localparam int IndexBits  = 9;
    localparam int LcBits     = $clog2(WordBits + 1);
    localparam int AvailBits  = $clog2(AccBits + 1);
    localparam int NBits      = $clog2(MaxResults);
    localparam int ShBits     = $clog2(FieldMax);
    localparam int QueueDepth = 2;
    localparam int QPtrBits   = $clog2(QueueDepth);
    localparam int QCntBits   = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        CFG_FIRST_WIDTH  = 2'd0,
        CFG_FIRST_COUNT  = 2'd1,
        CFG_SECOND_WIDTH = 2'd2,
        CFG_SECOND_COUNT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [WidthBits-1:0] first_width;
        logic [CntBits-1:0]   first_count;
        logic [WidthBits-1:0] second_width;
        logic [CntBits-1:0]   second_count;
    } cfg_t;

    typedef struct packed {
        logic [WordBits-1:0] word;
        logic                start;
    } item_t;

    typedef struct packed {
        logic [CntBits-1:0] cnt;
        logic               second;
        logic               complete;
    } rec_t;

    typedef struct packed {
        logic [FieldMax-1:0]  value;
        logic [IndexBits-1:0] field_index;
        logic                 group;
        logic                 last_of_word;
        logic                 record_done;
    } result_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXTRACT
    } back_state_t;

    function automatic logic [WidthBits-1:0] clamp_width(input logic [WidthBits-1:0] w);
        logic [WidthBits-1:0] r;
        r = w;
        if (w == '0)
        begin
            r = WidthBits'(1);
        end
        else if (w > WidthBits'(FieldMax))
        begin
            r = WidthBits'(FieldMax);
        end
        return r;
    endfunction

    function automatic rec_t settle(input rec_t s, input cfg_t c);
        rec_t r;
        r = s;
        if (!r.complete)
        begin
            if (!r.second && (r.cnt >= c.first_count))
            begin
                r.second = 1'b1;
                r.cnt    = '0;
            end
            if (r.second && (r.cnt >= c.second_count))
            begin
                r.complete = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/msb_first_field_unpacker_top.sv
// Channel   Direction  Signals                         Payload
// s_        in         s_tvalid s_tready s_tdata s_tuser  word, start_req
// m_        out        m_tvalid m_tready m_tdata m_tlast m_tuser  one field
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// A word is first merged with leftover bits in the extraction engine, then
// emits one field it completes per cycle while the output is free: n = 1..32
// fields (2 or 3 for 12-bit fields). A word arriving on a closed record is dropped.
// A two-entry input queue and a one-entry output register decouple the sides;
// a held output transfer stalls the engine until m_tready.
// Reset leaves the record closed; words are ignored until one carries start_req.
`default_nettype none

module msb_first_field_unpacker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] word
    input  wire logic [0:0]  s_tuser,    // [0] start_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [15:0] value, [24:16] field_index, [31:25] zero
    output logic             m_tlast,
    output logic [1:0]       m_tuser,    // [0] group, [1] record_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import mffu_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    item_t    s_item;
    item_t    q_item;
    logic     q_valid;
    logic     q_pop;
    result_t  m_result;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FIRST_WIDTH:  cfg_next.first_width  = cfg_data[WidthBits-1:0];
                CFG_FIRST_COUNT:  cfg_next.first_count  = cfg_data[CntBits-1:0];
                CFG_SECOND_WIDTH: cfg_next.second_width = cfg_data[WidthBits-1:0];
                CFG_SECOND_COUNT: cfg_next.second_count = cfg_data[CntBits-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{first_width: WidthBits'(12), first_count: CntBits'(63),
                         second_width: WidthBits'(2), second_count: CntBits'(63)};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_item = '{word: s_tdata, start: s_tuser[0]};

    mffu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    mffu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {7'b0, m_result.field_index, m_result.value};
    assign m_tlast = m_result.last_of_word;
    assign m_tuser = {m_result.record_done, m_result.group};

`ifndef SYNTHESIS
    a_done_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("record end not marked as last transfer of its word");

    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[24:16] < {1'b0, cfg_reg.first_count})
        else $error("first group index beyond its count");

    a_second_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[24:16] < {1'b0, cfg_reg.second_count})
        else $error("second group index beyond its count");
`endif

endmodule

`default_nettype wire

### rtl/mffu_front.sv
`default_nettype none

module mffu_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire mffu_pkg::item_t s_item,
    output logic                 q_valid,
    output mffu_pkg::item_t      q_item,
    input  wire logic            q_pop
);
    import mffu_pkg::*;

    item_t                mem_reg [QueueDepth];
    logic [QPtrBits-1:0]  wr_ptr_reg;
    logic [QPtrBits-1:0]  wr_ptr_next;
    logic [QPtrBits-1:0]  rd_ptr_reg;
    logic [QPtrBits-1:0]  rd_ptr_next;
    logic [QCntBits-1:0]  count_reg;
    logic [QCntBits-1:0]  count_next;
    logic                 push;
    logic                 pop;

    assign s_ready = (count_reg != QCntBits'(QueueDepth));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPtrBits'(QueueDepth - 1)) ? '0
                        : wr_ptr_reg + QPtrBits'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPtrBits'(QueueDepth - 1)) ? '0
                        : rd_ptr_reg + QPtrBits'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCntBits'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCntBits'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

`default_nettype wire

### rtl/mffu_back.sv
`default_nettype none

module mffu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mffu_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire mffu_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output mffu_pkg::result_t    m_result
);
    import mffu_pkg::*;

    back_state_t            state_reg;
    back_state_t            state_next;
    rec_t                   rec_reg;
    rec_t                   rec_next;
    logic [WordBits-1:0]    buf_reg;
    logic [WordBits-1:0]    buf_next;
    logic [LcBits-1:0]      bits_reg;
    logic [LcBits-1:0]      bits_next;
    logic [AccBits-1:0]     acc_reg;
    logic [AccBits-1:0]     acc_next;
    logic [AvailBits-1:0]   avail_reg;
    logic [AvailBits-1:0]   avail_next;
    logic [NBits-1:0]       n_reg;
    logic [NBits-1:0]       n_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_reg;
    result_t                out_next;

    logic                   out_free;
    logic [WidthBits-1:0]   w_cur;
    logic [WidthBits-1:0]   w_nxt;
    logic [ShBits-1:0]      sh_amt;
    logic [FieldMax-1:0]    field_v;
    logic [AccBits-1:0]     acc_shift;
    logic [AvailBits-1:0]   avail_after;
    rec_t                   rec_inc;
    rec_t                   rec_adv;
    rec_t                   rec_start;
    rec_t                   rec_pop;
    logic [LcBits-1:0]      lc_pop;
    logic [WordBits-1:0]    buf_pop;
    logic [AccBits-1:0]     acc_load;
    logic                   stop;
    logic                   is_last;
    logic                   emit;
    logic                   fin;
    logic [AccBits-1:0]     fin_acc;
    logic [AvailBits-1:0]   fin_avail;
    logic                   fin_complete;

    assign out_free  = !out_valid_reg || m_ready;
    assign w_cur     = clamp_width(rec_reg.second ? cfg.second_width : cfg.first_width);
    assign sh_amt    = ShBits'(WidthBits'(FieldMax) - w_cur);
    assign field_v   = acc_reg[AccBits-1 -: FieldMax] >> sh_amt;
    assign acc_shift = acc_reg << w_cur;
    assign avail_after = avail_reg - AvailBits'(w_cur);

    always_comb
    begin
        rec_inc          = rec_reg;
        rec_inc.cnt      = rec_reg.cnt + CntBits'(1);
        rec_inc.complete = 1'b0;
    end

    assign rec_adv = settle(rec_inc, cfg);
    assign w_nxt   = clamp_width(rec_adv.second ? cfg.second_width : cfg.first_width);
    assign is_last = rec_adv.complete || (n_reg == NBits'(MaxResults - 1))
                   || (avail_after < AvailBits'(w_nxt));
    assign stop    = rec_reg.complete || (avail_reg < AvailBits'(w_cur));

    always_comb
    begin
        rec_start = rec_reg;
        if (q_item.start)
        begin
            rec_start = '{cnt: '0, second: 1'b0, complete: 1'b0};
        end
    end

    assign rec_pop  = settle(rec_start, cfg);
    assign lc_pop   = q_item.start ? '0 : bits_reg;
    assign buf_pop  = q_item.start ? '0 : buf_reg;
    assign acc_load = {buf_pop, {WordBits{1'b0}}}
                    | ({q_item.word, {WordBits{1'b0}}} >> lc_pop);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && !rec_pop.complete)
                begin
                    state_next = BK_EXTRACT;
                end
            end
            BK_EXTRACT:
            begin
                if (stop || (out_free && is_last))
                begin
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        q_pop        = 1'b0;
        emit         = 1'b0;
        fin          = 1'b0;
        fin_acc      = acc_reg;
        fin_avail    = avail_reg;
        fin_complete = rec_reg.complete;
        rec_next     = rec_reg;
        buf_next     = buf_reg;
        bits_next    = bits_reg;
        acc_next     = acc_reg;
        avail_next   = avail_reg;
        n_next       = n_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rec_next   = rec_pop;
                    buf_next   = buf_pop;
                    bits_next  = lc_pop;
                    acc_next   = acc_load;
                    avail_next = AvailBits'(lc_pop) + AvailBits'(WordBits);
                    n_next     = '0;
                end
            end
            BK_EXTRACT:
            begin
                if (stop)
                begin
                    fin = 1'b1;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    rec_next   = rec_adv;
                    acc_next   = acc_shift;
                    avail_next = avail_after;
                    n_next     = n_reg + NBits'(1);
                    if (is_last)
                    begin
                        fin          = 1'b1;
                        fin_acc      = acc_shift;
                        fin_avail    = avail_after;
                        fin_complete = rec_adv.complete;
                    end
                end
            end
        endcase
        if (fin)
        begin
            if (fin_complete)
            begin
                buf_next  = '0;
                bits_next = '0;
            end
            else
            begin
                buf_next  = fin_acc[AccBits-1 -: WordBits];
                bits_next = (fin_avail > AvailBits'(WordBits)) ? LcBits'(WordBits)
                          : LcBits'(fin_avail);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next           = 1'b1;
            out_next.value           = field_v & ((FieldMax'(1) << w_cur) - FieldMax'(1));
            out_next.field_index     = IndexBits'(rec_reg.cnt);
            out_next.group           = rec_reg.second;
            out_next.last_of_word    = is_last;
            out_next.record_done     = rec_adv.complete;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rec_reg       <= '{cnt: '0, second: 1'b0, complete: 1'b1};
            buf_reg       <= '0;
            bits_reg      <= '0;
            n_reg         <= '0;
            avail_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rec_reg       <= rec_next;
            buf_reg       <= buf_next;
            bits_reg      <= bits_next;
            n_reg         <= n_next;
            avail_reg     <= avail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

endmodule

`default_nettype wire
